### rtl/core/rnpp_pkg.sv
// Shared types, constants and reset values for the ray nearest point pick block.
// No dependencies.
`default_nettype none
package rnpp_pkg;

	localparam int GRID_ROWS = 4;
	localparam int GRID_COLS = 4;
	localparam int NPTS      = GRID_ROWS * GRID_COLS;
	localparam int PT_W      = $clog2(NPTS);
	localparam int ROW_IW    = $clog2(GRID_ROWS);
	localparam int COL_IW    = $clog2(GRID_COLS);

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] BEST_START  = 32'h7D00_0000;
	localparam logic [31:0] LIMIT_RESET = 32'h0000_8000;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PICK = 1'b1;

	// accumulate modes for the multiplier result
	localparam logic [2:0] M_NONE = 3'd0;
	localparam logic [2:0] M_VV   = 3'd1;
	localparam logic [2:0] M_CADD = 3'd2;
	localparam logic [2:0] M_CSUB = 3'd3;
	localparam logic [2:0] M_SQ0  = 3'd4;
	localparam logic [2:0] M_SQ18 = 3'd5;
	localparam logic [2:0] M_SQ34 = 3'd6;

	typedef struct packed {
		logic               command;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] dst;
	} tag_t;

	typedef struct packed {
		logic        stb;
		logic        hit;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] sq_dist;
	} res_t;

	function automatic point_t pt_reset(input int r, input int c);
		point_t p;
		logic   inner;
		inner = (r == 1 || r == 2) && (c == 1 || c == 2);
		p.x = 16'((2 * r - 3) * 256);
		p.y = 16'((2 * c - 3) * 256);
		p.z = inner ? 16'(7 * 256) : 16'(-3 * 256);
		return p;
	endfunction

endpackage
`default_nettype wire

### rtl/core/ray_nearest_point_pick_core.sv
// Top level of the ray nearest point pick block.
// Depends on rnpp_pkg, rnpp_front, rnpp_back (and rnpp_div below it).
`default_nettype none
// A command word is taken at a rising edge with start high and busy low; busy only
// rises when the two-word command queue is full. A load word gives no result. A pick
// word gives exactly one result, shown for a single cycle with result_valid high; the
// receiver cannot stall it, so it must take it then. Per point, a pick makes 6
// cross-product and 9 squaring passes through one shared 18x18 multiplier, then a
// 32-step restoring divider does the division by |v|^2. A zero direction ends the pick
// with no hit. Write dist_limit (cfg_we, cfg_wdata) only while the block is idle.
module ray_nearest_point_pick_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic [1:0]         row,
	input  wire logic [1:0]         col,
	input  wire logic signed [15:0] coord_x,
	input  wire logic signed [15:0] coord_y,
	input  wire logic signed [15:0] coord_z,
	input  wire logic signed [15:0] dir_x,
	input  wire logic signed [15:0] dir_y,
	input  wire logic signed [15:0] dir_z,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata,
	output logic                    result_valid,
	output logic                    hit,
	output logic [1:0]              sel_row,
	output logic [1:0]              sel_col,
	output logic [31:0]             best_dist
);
	rnpp_pkg::item_t item_in, head;
	rnpp_pkg::res_t  res;
	logic            head_vld, pop;
	logic [31:0]     dist_limit_q;

	// threshold register, unsigned Q16.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dist_limit_q <= rnpp_pkg::LIMIT_RESET;
		else if (cfg_we)
			dist_limit_q <= cfg_wdata;
	end

	assign item_in = '{command: command, row: row, col: col,
		coord_x: coord_x, coord_y: coord_y, coord_z: coord_z,
		dir_x: dir_x, dir_y: dir_y, dir_z: dir_z};

	// front: accept and queue command words
	rnpp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_in  (item_in),
		.busy     (busy),
		.head     (head),
		.head_vld (head_vld),
		.pop      (pop)
	);

	// back: loads into the store, picks through the scan
	rnpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_vld   (head_vld),
		.pop        (pop),
		.dist_limit (dist_limit_q),
		.res        (res)
	);

	assign result_valid = res.stb;
	assign hit          = res.hit;
	assign sel_row      = res.row;
	assign sel_col      = res.col;
	assign best_dist    = res.sq_dist;
endmodule
`default_nettype wire

### rtl/core/rnpp_front.sv
// Front end: takes command words and holds them in a short queue for the back end.
// Depends on rnpp_pkg.
`default_nettype none
module rnpp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire rnpp_pkg::item_t item_in,
	output logic                busy,
	output rnpp_pkg::item_t     head,
	output logic                head_vld,
	input  wire logic           pop
);
	rnpp_pkg::item_t               q_mem_q [rnpp_pkg::Q_DEPTH];
	logic [rnpp_pkg::Q_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [rnpp_pkg::Q_CW-1:0]     cnt_q;
	logic                          push, do_pop;

	assign busy     = (cnt_q == rnpp_pkg::Q_CW'(rnpp_pkg::Q_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = q_mem_q[rd_ptr_q];
	assign push     = start && !busy;
	assign do_pop   = pop && head_vld;

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == rnpp_pkg::Q_AW'(rnpp_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == rnpp_pkg::Q_AW'(rnpp_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/rnpp_div.sv
// Restoring divider, one quotient bit a cycle, 68 by 32 bits to a saturated 32-bit quotient.
// Self-contained.
`default_nettype none
module rnpp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [67:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [31:0]      quo
);
	logic [31:0] rem_q, sh_q, quo_q;
	logic        sat_q, run_q, done_q;
	logic [5:0]  cnt_q;
	logic [32:0] r2, r2_sub;
	logic        ge;

	assign r2     = {rem_q, sh_q[31]};
	assign ge     = (r2 >= {1'b0, den});
	assign r2_sub = r2 - {1'b0, den};
	assign done   = done_q;
	assign quo    = sat_q ? 32'hFFFF_FFFF : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= (num[67:32] >= {4'b0, den});
			rem_q <= num[63:32];
			sh_q  <= num[31:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? r2_sub[31:0] : r2[31:0];
			sh_q  <= {sh_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/rnpp_back.sv
// Back end: point store, shared multiplier sequencer and nearest point scan.
// Depends on rnpp_pkg and rnpp_div.
`default_nettype none
module rnpp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rnpp_pkg::item_t head,
	input  wire logic            head_vld,
	output logic                 pop,
	input  wire logic [31:0]     dist_limit,
	output rnpp_pkg::res_t       res
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_VV    = 4'd1;
	localparam logic [3:0] S_VVW   = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_CROSS = 4'd4;
	localparam logic [3:0] S_SQ    = 4'd5;
	localparam logic [3:0] S_SQW   = 4'd6;
	localparam logic [3:0] S_DVS   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_CMP   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] ph_q, st_q;

	rnpp_pkg::point_t store_q [rnpp_pkg::NPTS];
	logic [rnpp_pkg::PT_W-1:0]   pt_q, ld_idx;
	logic [rnpp_pkg::ROW_IW-1:0] r_q;
	logic [rnpp_pkg::COL_IW-1:0] c_q;
	logic                        ld_ok, last_pt;

	logic signed [15:0] ox_q, oy_q, oz_q, vx_q, vy_q, vz_q;
	logic signed [16:0] dx_q, dy_q, dz_q;
	logic [31:0]        vv_q;
	logic signed [34:0] cr_q [3];
	logic [67:0]        acc_q;

	logic signed [17:0] opa, opb;
	rnpp_pkg::tag_t     tg, tag_s1;
	logic signed [35:0] p_s1;

	logic [33:0] mg [3];
	logic [16:0] mh [3], ml [3];

	logic [31:0] best_q;
	logic        hit_q;
	logic [1:0]  sel_row_q, sel_col_q;

	logic        div_done;
	logic [31:0] div_quo;
	logic        take;

	function automatic logic [33:0] mag34(input logic signed [34:0] v);
		logic signed [34:0] n;
		n = (v < 0) ? -v : v;
		return n[33:0];
	endfunction

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mg[j] = mag34(cr_q[j]);
			mh[j] = mg[j][33:17];
			ml[j] = mg[j][16:0];
		end
	end

	// multiplier operand schedule
	always_comb begin
		opa = '0;
		opb = '0;
		tg  = '{mode: rnpp_pkg::M_NONE, dst: 2'd0};
		unique case (ph_q)
			S_VV: begin
				tg.mode = rnpp_pkg::M_VV;
				case (st_q)
					4'd0:    begin opa = 18'(vx_q); opb = 18'(vx_q); end
					4'd1:    begin opa = 18'(vy_q); opb = 18'(vy_q); end
					default: begin opa = 18'(vz_q); opb = 18'(vz_q); end
				endcase
			end
			S_CROSS: begin
				case (st_q)
					4'd0: begin opa = 18'(dy_q); opb = 18'(vz_q);
						tg = '{mode: rnpp_pkg::M_CADD, dst: 2'd0}; end
					4'd1: begin opa = 18'(dz_q); opb = 18'(vy_q);
						tg = '{mode: rnpp_pkg::M_CSUB, dst: 2'd0}; end
					4'd2: begin opa = 18'(dz_q); opb = 18'(vx_q);
						tg = '{mode: rnpp_pkg::M_CADD, dst: 2'd1}; end
					4'd3: begin opa = 18'(dx_q); opb = 18'(vz_q);
						tg = '{mode: rnpp_pkg::M_CSUB, dst: 2'd1}; end
					4'd4: begin opa = 18'(dx_q); opb = 18'(vy_q);
						tg = '{mode: rnpp_pkg::M_CADD, dst: 2'd2}; end
					default: begin opa = 18'(dy_q); opb = 18'(vx_q);
						tg = '{mode: rnpp_pkg::M_CSUB, dst: 2'd2}; end
				endcase
			end
			S_SQ: begin
				case (st_q)
					4'd0: begin opa = {1'b0, ml[0]}; opb = {1'b0, ml[0]};
						tg.mode = rnpp_pkg::M_SQ0; end
					4'd1: begin opa = {1'b0, mh[0]}; opb = {1'b0, ml[0]};
						tg.mode = rnpp_pkg::M_SQ18; end
					4'd2: begin opa = {1'b0, mh[0]}; opb = {1'b0, mh[0]};
						tg.mode = rnpp_pkg::M_SQ34; end
					4'd3: begin opa = {1'b0, ml[1]}; opb = {1'b0, ml[1]};
						tg.mode = rnpp_pkg::M_SQ0; end
					4'd4: begin opa = {1'b0, mh[1]}; opb = {1'b0, ml[1]};
						tg.mode = rnpp_pkg::M_SQ18; end
					4'd5: begin opa = {1'b0, mh[1]}; opb = {1'b0, mh[1]};
						tg.mode = rnpp_pkg::M_SQ34; end
					4'd6: begin opa = {1'b0, ml[2]}; opb = {1'b0, ml[2]};
						tg.mode = rnpp_pkg::M_SQ0; end
					4'd7: begin opa = {1'b0, mh[2]}; opb = {1'b0, ml[2]};
						tg.mode = rnpp_pkg::M_SQ18; end
					default: begin opa = {1'b0, mh[2]}; opb = {1'b0, mh[2]};
						tg.mode = rnpp_pkg::M_SQ34; end
				endcase
			end
			default: ;
		endcase
	end

	assign pop     = (ph_q == S_IDLE) && head_vld;
	assign ld_ok   = (int'(head.row) < rnpp_pkg::GRID_ROWS) &&
		(int'(head.col) < rnpp_pkg::GRID_COLS);
	assign ld_idx  = rnpp_pkg::PT_W'(int'(head.row) * rnpp_pkg::GRID_COLS + int'(head.col));
	assign last_pt = (r_q == rnpp_pkg::ROW_IW'(rnpp_pkg::GRID_ROWS - 1)) &&
		(c_q == rnpp_pkg::COL_IW'(rnpp_pkg::GRID_COLS - 1));
	assign take    = (div_quo < best_q) && (div_quo < dist_limit);

	rnpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ph_q == S_DVS),
		.num    (acc_q),
		.den    (vv_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// point store, reset to the demo surface
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rnpp_pkg::GRID_ROWS; r++)
				for (int c = 0; c < rnpp_pkg::GRID_COLS; c++)
					store_q[r * rnpp_pkg::GRID_COLS + c] <= rnpp_pkg::pt_reset(r, c);
		end else if (pop && head.command == rnpp_pkg::CMD_LOAD && ld_ok) begin
			store_q[ld_idx] <= '{x: head.coord_x, y: head.coord_y, z: head.coord_z};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_s1 <= 36'(opa) * 36'(opb);
		if (pop && head.command == rnpp_pkg::CMD_PICK) begin
			ox_q <= head.coord_x; oy_q <= head.coord_y; oz_q <= head.coord_z;
			vx_q <= head.dir_x;   vy_q <= head.dir_y;   vz_q <= head.dir_z;
			vv_q <= '0;
		end
		if (ph_q == S_DIFF) begin
			dx_q  <= 17'(store_q[pt_q].x) - 17'(ox_q);
			dy_q  <= 17'(store_q[pt_q].y) - 17'(oy_q);
			dz_q  <= 17'(store_q[pt_q].z) - 17'(oz_q);
			acc_q <= '0;
			for (int j = 0; j < 3; j++)
				cr_q[j] <= '0;
		end else begin
			case (tag_s1.mode)
				rnpp_pkg::M_VV:   vv_q <= vv_q + p_s1[31:0];
				rnpp_pkg::M_CADD: cr_q[tag_s1.dst] <= cr_q[tag_s1.dst] + 35'(p_s1);
				rnpp_pkg::M_CSUB: cr_q[tag_s1.dst] <= cr_q[tag_s1.dst] - 35'(p_s1);
				rnpp_pkg::M_SQ0:  acc_q <= acc_q + 68'(p_s1[33:0]);
				rnpp_pkg::M_SQ18: acc_q <= acc_q + (68'(p_s1[33:0]) << 18);
				rnpp_pkg::M_SQ34: acc_q <= acc_q + (68'(p_s1[33:0]) << 34);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= S_IDLE;
			st_q      <= '0;
			tag_s1    <= '{mode: rnpp_pkg::M_NONE, dst: 2'd0};
			pt_q      <= '0;
			r_q       <= '0;
			c_q       <= '0;
			best_q    <= rnpp_pkg::BEST_START;
			hit_q     <= 1'b0;
			sel_row_q <= '0;
			sel_col_q <= '0;
		end else begin
			tag_s1 <= tg;
			unique case (ph_q)
				S_IDLE: begin
					if (pop && head.command == rnpp_pkg::CMD_PICK) begin
						ph_q   <= S_VV;
						st_q   <= '0;
						pt_q   <= '0;
						r_q    <= '0;
						c_q    <= '0;
						best_q <= rnpp_pkg::BEST_START;
						hit_q  <= 1'b0;
					end
				end
				S_VV: begin
					st_q <= st_q + 1'b1;
					if (st_q == 4'd2)
						ph_q <= S_VVW;
				end
				S_VVW: ph_q <= S_DIFF;
				S_DIFF: begin
					st_q <= '0;
					ph_q <= (vv_q == '0) ? S_OUT : S_CROSS;
				end
				S_CROSS: begin
					st_q <= st_q + 1'b1;
					if (st_q == 4'd5) begin
						st_q <= '0;
						ph_q <= S_SQ;
					end
				end
				S_SQ: begin
					st_q <= st_q + 1'b1;
					if (st_q == 4'd8)
						ph_q <= S_SQW;
				end
				S_SQW: ph_q <= S_DVS;
				S_DVS: ph_q <= S_DIV;
				S_DIV: if (div_done) ph_q <= S_CMP;
				S_CMP: begin
					if (take) begin
						best_q    <= div_quo;
						hit_q     <= 1'b1;
						sel_row_q <= 2'(r_q);
						sel_col_q <= 2'(c_q);
					end
					if (last_pt) begin
						ph_q <= S_OUT;
					end else begin
						ph_q <= S_DIFF;
						pt_q <= pt_q + 1'b1;
						if (c_q == rnpp_pkg::COL_IW'(rnpp_pkg::GRID_COLS - 1)) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_OUT: ph_q <= S_IDLE;
				default: ph_q <= S_IDLE;
			endcase
		end
	end

	assign res = '{stb: (ph_q == S_OUT), hit: hit_q, row: sel_row_q, col: sel_col_q,
		sq_dist: hit_q ? best_q : 32'd0};

	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.stb && res.hit) |-> (res.sq_dist < dist_limit))
		else $error("hit reported at or above the limit");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		res.stb |=> !res.stb)
		else $error("result strobe longer than one cycle");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (ph_q == S_IDLE))
		else $error("queue popped while a pick is running");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (ph_q == S_DIV))
		else $error("divider finished outside its wait state");
endmodule
`default_nettype wire
